// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/xlb_pkg.sv -----
// ---------------------------------------------------------------------------
// xlb_pkg
// Shared types and constants of the XOR linear basis engine.
// ---------------------------------------------------------------------------
package xlb_pkg;

  localparam int DATA_W    = 64;   // width of value, order and answer
  localparam int SIZE_W    = 7;    // width of basis_size
  localparam int S_TDATA_W = 136;  // op + value + order, padded to bytes
  localparam int M_TDATA_W = 72;   // answer + ok + basis_size

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_KTH    = 2'd1,
    OP_COUNT  = 2'd2,
    OP_RANK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PLACE,
    ST_FINISH
  } state_t;

  // What the current walk over the basis memory does.
  typedef enum logic [1:0] {
    PH_REDUCE,   // descending walk, clears pivot bits of the word
    PH_KTH,      // ascending walk, combines words chosen by the order bits
    PH_UPDATE    // ascending walk, clears the new pivot from older words
  } phase_t;

  // One result item; the first member lands in the highest bits.
  typedef struct packed {
    logic [SIZE_W-1:0] basis_size;
    logic              ok;
    logic [DATA_W-1:0] answer;
  } res_t;

endpackage

// ----- rtl/xlb_basis_ram.sv -----
// ---------------------------------------------------------------------------
// xlb_basis_ram
// Basis word store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module xlb_basis_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/xlb_core.sv -----
// ---------------------------------------------------------------------------
// xlb_core
// Sequencer and datapath: walks the basis memory once or twice per item.
// ---------------------------------------------------------------------------
module xlb_core import xlb_pkg::*; #(
  parameter int BITS        = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  op_t                     in_op,
  input  logic [DATA_W-1:0]       in_value,
  input  logic [DATA_W-1:0]       in_order,
  output logic                    out_valid,
  input  logic                    out_ready,
  output res_t                    out_res,
  output logic                    ram_we,
  output logic [$clog2(BITS)-1:0] ram_waddr,
  output logic [BITS-1:0]         ram_wdata,
  output logic [$clog2(BITS)-1:0] ram_raddr,
  input  logic [BITS-1:0]         ram_rdata
);

  localparam int AW = $clog2(BITS);
  localparam logic [AW-1:0] LAST = AW'(BITS - 1);

  state_t               state, state_next;
  phase_t               phase;
  op_t                  op;
  logic [AW-1:0]        cnt;
  logic                 pvalid;
  logic [AW-1:0]        pb;
  logic [BITS-1:0]      x;
  logic [DATA_W-1:0]    kreg;
  logic                 kzero;
  logic                 has_dep;
  logic [BITS-1:0]      ans;
  logic [DATA_W-1:0]    id;
  logic                 found;
  logic [AW-1:0]        pidx;
  logic [BITS-1:0]      pm;
  logic [BITS-1:0]      pivot;
  logic [SIZE_W-1:0]    rank;
  logic [COUNT_WIDTH-1:0] inserted;

  logic                   accept;
  logic                   hit;
  logic                   found_now;
  logic [COUNT_WIDTH-1:0] rank_ext;
  logic                   dep_now;
  logic [COUNT_WIDTH-1:0] excess;
  logic [DATA_W-1:0]      count_ans;
  logic [DATA_W-1:0]      id_inc;
  logic                   kth_ok;
  logic                   xzero;

  assign accept   = in_valid && in_ready;
  assign rank_ext = COUNT_WIDTH'(rank);
  assign dep_now  = inserted > rank_ext;

  // First free bit met by the descending walk becomes the new pivot.
  assign hit = pvalid && (phase == PH_REDUCE) && !pivot[pb] && x[pb] && !found;
  assign found_now = found || hit;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cnt == LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (phase == PH_REDUCE && op == OP_INSERT && found_now) begin
          state_next = ST_ISSUE;
        end else if (phase == PH_UPDATE) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_PLACE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_FINISH);
    ram_raddr = (phase == PH_REDUCE) ? (LAST - cnt) : cnt;
    if (state == ST_PLACE) begin
      ram_we    = 1'b1;
      ram_waddr = pidx;
      ram_wdata = x;
    end else begin
      ram_we    = pvalid && (phase == PH_UPDATE) && pivot[pb] && (|(ram_rdata & pm));
      ram_waddr = pb;
      ram_wdata = ram_rdata ^ x;
    end
  end

  // Result of the finished item.
  always_comb begin
    excess    = inserted - rank_ext;
    count_ans = (excess >= COUNT_WIDTH'(DATA_W)) ? '1 : (DATA_W'(1) << excess[5:0]);
    id_inc    = (has_dep && (id != '1)) ? id + DATA_W'(1) : id;
    kth_ok    = !kzero && (kreg == '0);
    xzero     = (x == '0);
    out_res.basis_size = rank;
    out_res.ok         = 1'b0;
    out_res.answer     = '0;
    unique case (op)
      OP_INSERT: begin
        out_res.ok = found;
      end
      OP_KTH: begin
        out_res.ok     = kth_ok;
        out_res.answer = kth_ok ? DATA_W'(ans) : '0;
      end
      OP_COUNT: begin
        out_res.ok     = xzero;
        out_res.answer = xzero ? count_ans : '0;
      end
      OP_RANK: begin
        out_res.ok     = xzero && (id_inc != '0);
        out_res.answer = (xzero && (id_inc != '0)) ? id_inc : '0;
      end
      default: begin
        out_res.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pvalid   <= 1'b0;
      pivot    <= '0;
      rank     <= '0;
      inserted <= '0;
    end else begin
      state  <= state_next;
      pvalid <= (state == ST_ISSUE);
      pb     <= ram_raddr;

      if (accept) begin
        op      <= in_op;
        x       <= in_value[BITS-1:0];
        kzero   <= (in_order == '0);
        has_dep <= dep_now;
        kreg    <= dep_now ? in_order - DATA_W'(1) : in_order;
        ans     <= '0;
        id      <= '0;
        found   <= 1'b0;
        cnt     <= '0;
        phase   <= (in_op == OP_KTH) ? PH_KTH : PH_REDUCE;
        if (in_op == OP_INSERT && inserted != '1) begin
          inserted <= inserted + COUNT_WIDTH'(1);
        end
      end

      if (state == ST_ISSUE) begin
        cnt <= (cnt == LAST) ? '0 : cnt + AW'(1);
      end

      if (pvalid) begin
        case (phase)
          PH_REDUCE: begin
            if (pivot[pb]) begin
              id <= {id[DATA_W-2:0], x[pb]};
              if (x[pb]) x <= x ^ ram_rdata;
            end else if (hit) begin
              found <= 1'b1;
              pidx  <= pb;
              pm    <= BITS'(1) << pb;
            end
          end
          PH_KTH: begin
            if (pivot[pb]) begin
              if (kreg[0]) ans <= ans ^ ram_rdata;
              kreg <= kreg >> 1;
            end
          end
          default: begin
          end
        endcase
      end

      if (state == ST_DRAIN && phase == PH_REDUCE && op == OP_INSERT && found_now) begin
        phase <= PH_UPDATE;
      end

      if (state == ST_PLACE) begin
        pivot <= pivot | pm;
        rank  <= rank + SIZE_W'(1);
      end
    end
  end

endmodule

// ----- rtl/xlb_out_reg.sv -----
// ---------------------------------------------------------------------------
// xlb_out_reg
// Output register that holds one result item until the sink takes it.
// ---------------------------------------------------------------------------
module xlb_out_reg import xlb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  res_t                 in_res,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  res_t held;

  assign in_ready = !m_tvalid || m_tready;
  assign m_tdata  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        m_tvalid <= in_valid;
        if (in_valid) held <= in_res;
      end
    end
  end

endmodule

// ----- rtl/xor_linear_basis_engine.sv -----
// ---------------------------------------------------------------------------
// xor_linear_basis_engine
// Reduced row-echelon XOR basis over GF(2) with insert and query operations.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Contents (lowest bits first)
//   s_       in         op[1:0], value[63:0], order[63:0], zero pad
//   m_       out        answer[63:0], ok, basis_size[6:0]
//
// Each item walks the basis memory one entry per cycle through its read port.
// Count, rank, kth and dependent inserts offer their result after one walk;
// an independent insert walks again and files the word before offering it.
// The next item is accepted the cycle after the result enters the output register.
// Reset clears the pivot mask, rank and insert count; a memory entry is used only
// while its pivot bit is set. A stalled sink holds the engine at its finish step.
//
module xor_linear_basis_engine import xlb_pkg::*; #(
  parameter int BITS        = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // op[1:0], value[65:2], order[129:66], pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // answer[63:0], ok[64], basis_size[71:65]
);

  localparam int AW = $clog2(BITS);

  // Core to memory.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [BITS-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [BITS-1:0] ram_rdata;

  // Core to output register.
  logic res_valid;
  logic res_ready;
  res_t res;

  xlb_basis_ram #(
    .DEPTH (BITS),
    .WIDTH (BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The core unpacks the input item straight from the stream.
  xlb_core #(
    .BITS        (BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op_t'(s_tdata[1:0])),
    .in_value  (s_tdata[65:2]),
    .in_order  (s_tdata[129:66]),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_res   (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  xlb_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_res   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/xlb_checker.sv -----
// ---------------------------------------------------------------------------
// xlb_checker
// Port-level checks of the XOR linear basis engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xlb_checker import xlb_pkg::*; #(
  parameter int BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Items accepted whose result has not yet been taken.
  logic [1:0] pending;
  logic [1:0] pending_next;

  always_comb begin
    pending_next = pending;
    if (s_tvalid && s_tready) pending_next = pending_next + 2'd1;
    if (m_tvalid && m_tready) pending_next = pending_next - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending_next;
    end
  end

  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `ASSERT_IMPLY(a_no_extra_result, m_tvalid, pending != 2'd0, "result offered without an item")
  `ASSERT_IMPLY(a_fail_zero, m_tvalid && !m_tdata[64], m_tdata[63:0] == '0, "answer nonzero with ok low")
  `ASSERT_IMPLY(a_size_range, m_tvalid, m_tdata[71:65] <= 7'(BITS), "basis size beyond word width")
  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted while one is in work")

endmodule

bind xor_linear_basis_engine xlb_checker #(.BITS(BITS)) u_xlb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR linear basis engine: a behavioral copy of
// the GF(2) basis predicts every result item, which is compared field by
// field as the engine hands it over, under several patterns of idling.
// ---------------------------------------------------------------------------
module tb;
  import xlb_pkg::*;

  // The longest item, an independent insert, walks the basis twice; a run of
  // quiet cycles past WATCHDOG_LIMIT can only mean a hang.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 140;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;    // op[1:0], value[65:2], order[129:66], pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;    // answer[63:0], ok[64], basis_size[71:65]

  xor_linear_basis_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Predictor state: the reduced basis filed by pivot, the pivot mask, the
  // number of basis words and the saturating count of inserted words.
  logic [DATA_W-1:0] basis_rows [DATA_W];
  logic [DATA_W-1:0] pivot_mask;
  logic [SIZE_W-1:0] rank_now;
  logic [31:0]       insert_total;

  res_t results_due [$];
  int   mismatches;
  int   op_seen [4];
  int   ok_seen;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  res_t want;
  res_t got;

  function automatic logic [DATA_W-1:0] low_mask(int w);
    return (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [DATA_W-1:0] wide_random();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic dependent_seen();
    return insert_total > {25'd0, rank_now};
  endfunction

  // Clears every pivot bit of the word, highest pivot first.
  function automatic logic [DATA_W-1:0] reduce_by_basis(logic [DATA_W-1:0] x);
    for (int b = DATA_W - 1; b >= 0; b--) begin
      if (pivot_mask[b] && x[b]) begin
        x ^= basis_rows[b];
      end
    end
    return x;
  endfunction

  // XOR of a random subset of the basis: always a reachable word.
  function automatic logic [DATA_W-1:0] span_word();
    logic [DATA_W-1:0] x;
    x = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (pivot_mask[b] && $urandom_range(1)) begin
        x ^= basis_rows[b];
      end
    end
    return x;
  endfunction

  // Applies one operation to the predicted basis and returns its result item.
  function automatic res_t basis_step(op_t op, logic [DATA_W-1:0] value,
                                     logic [DATA_W-1:0] order);
    res_t              r;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] id;
    logic [31:0]       surplus;
    int                p;
    int                i;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (insert_total != '1) begin
          insert_total = insert_total + 32'd1;
        end
        x = reduce_by_basis(value);
        if (x != '0) begin
          p = DATA_W - 1;
          while (p > 0 && !x[p]) p--;
          // Keep the basis fully reduced: no older word keeps the new pivot.
          for (int b = 0; b < DATA_W; b++) begin
            if (pivot_mask[b] && basis_rows[b][p]) begin
              basis_rows[b] ^= x;
            end
          end
          basis_rows[p] = x;
          pivot_mask[p] = 1'b1;
          rank_now = rank_now + 7'd1;
          r.ok = 1'b1;
        end
      end
      OP_KTH: begin
        if (order != '0) begin
          // With a dependent word, zero is the smallest reachable XOR.
          k = dependent_seen() ? order - 64'd1 : order;
          if (rank_now >= DATA_W || (k >> rank_now) == '0) begin
            i = 0;
            for (int b = 0; b < DATA_W; b++) begin
              if (pivot_mask[b]) begin
                if (k[i]) begin
                  r.answer ^= basis_rows[b];
                end
                i++;
              end
            end
            r.ok = 1'b1;
          end
        end
      end
      OP_COUNT: begin
        if (reduce_by_basis(value) == '0) begin
          surplus = insert_total - {25'd0, rank_now};
          r.answer = (surplus >= DATA_W) ? '1 : (64'd1 << surplus);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (reduce_by_basis(value) == '0) begin
          id = '0;
          i = 0;
          for (int b = 0; b < DATA_W; b++) begin
            if (pivot_mask[b]) begin
              id[i] = value[b];
              i++;
            end
          end
          if (dependent_seen() && id != '1) begin
            id = id + 64'd1;
          end
          if (id != '0) begin
            r.answer = id;
            r.ok = 1'b1;
          end
        end
      end
    endcase
    r.basis_size = rank_now;
    return r;
  endfunction

  // Offers one item after a random gap and records its expected result once
  // it is taken. Valid is left high so a following item can go out
  // back to back.
  task automatic send_item(op_t op, logic [DATA_W-1:0] value, logic [DATA_W-1:0] order);
    res_t r;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, order, value, op};
    do @(posedge clk); while (!s_tready);
    r = basis_step(op, value, order);
    results_due.push_back(r);
    op_seen[op]++;
    if (r.ok) ok_seen++;
  endtask

  // Drops valid and holds off until every outstanding result has come back.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Queries on an empty basis: nothing but zero-subset counting succeeds.
  task automatic test_empty_basis();
    send_item(OP_KTH,   '0,    64'd1);
    send_item(OP_KTH,   '0,    '0);
    send_item(OP_COUNT, '0,    '0);
    send_item(OP_COUNT, '1,    '1);
    send_item(OP_RANK,  '0,    '0);
  endtask

  // Independent and dependent inserts mixed with queries at the edges of
  // the reachable range.
  task automatic test_insert_and_query();
    send_item(OP_INSERT, '0, '0);        // zero is counted but dependent
    send_item(OP_RANK,   '0, '0);        // zero now reachable, first in order
    send_item(OP_COUNT,  '0, '0);
    send_item(OP_KTH,    '0, 64'd1);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, 64'd1, '0);
    send_item(OP_INSERT, 64'h8000_0000_0000_0000, '0);
    send_item(OP_INSERT, 64'h0000_0000_0000_5555, '0);
    send_item(OP_INSERT, 64'h8000_0000_0000_0001, '0);
    send_item(OP_KTH,    '0, '0);
    send_item(OP_KTH,    '0, (64'd1 << rank_now));
    send_item(OP_KTH,    '0, (64'd1 << rank_now) + 64'd1);
    send_item(OP_KTH,    '0, '1);
    send_item(OP_COUNT,  '1, '0);
    send_item(OP_COUNT,  64'd2, '0);
    send_item(OP_RANK,   64'h7FFF_FFFF_FFFF_AAAA, '0);
    send_item(OP_RANK,   64'd2, '0);
  endtask

  // Random operations. Inserted words are limited to the low `width` bits so
  // the basis grows in steps across phases; most inserts and queries use
  // words from the current span so that reachable cases dominate.
  task automatic test_random_traffic(int n, int width, int send_idle, int recv_stall,
                                     bit pause_midway);
    int                pick;
    int                kind;
    op_t               op;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] order;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int n_i = 0; n_i < n; n_i++) begin
      if (pause_midway && n_i == n / 2) begin
        wait_results_drained();
      end
      pick  = $urandom_range(99);
      kind  = $urandom_range(99);
      value = wide_random();
      order = wide_random();
      if (pick < 35) begin
        op = OP_INSERT;
        if (kind < 30) begin
          value = value & low_mask(width);
        end else if (kind < 85) begin
          value = span_word();
        end else if (kind < 93) begin
          value = '0;
        end else begin
          value = 64'd1 << $urandom_range(width - 1);
        end
      end else if (pick < 60) begin
        op = OP_KTH;
        if (kind < 60) begin
          order = (order & low_mask(rank_now)) + 64'd1;
        end else if (kind < 70) begin
          order = '0;
        end else if (kind < 85) begin
          // Just below, at and just past the end of the range.
          order = (rank_now >= DATA_W) ? '1 - 64'($urandom_range(1)) :
                  (64'd1 << rank_now) + 64'($urandom_range(2)) - 64'd1;
        end
      end else begin
        op = (pick < 80) ? OP_COUNT : OP_RANK;
        if (kind < 60) begin
          value = span_word();
        end else if (kind < 70) begin
          value = '0;
        end else if (kind < 85) begin
          value = span_word() ^ (64'd1 << $urandom_range(DATA_W - 1));
        end
      end
      send_item(op, value, order);
    end
  endtask

  // Fills every pivot, piles up dependent words past 64 so the subset count
  // saturates, then asks for the last position and the highest rank.
  task automatic test_full_basis_limits();
    idle_pct  = 0;
    stall_pct = 0;
    for (int b = DATA_W - 1; b >= 0; b--) begin
      send_item(OP_INSERT, 64'd1 << b, wide_random());
    end
    while ((insert_total - {25'd0, rank_now}) < 32'd65) begin
      send_item(OP_INSERT, '0, '0);
    end
    send_item(OP_COUNT, '1, '0);
    send_item(OP_COUNT, wide_random(), '0);
    send_item(OP_RANK,  '1, '0);               // position past 64 bits
    send_item(OP_RANK,  64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(OP_RANK,  '0, '0);
    send_item(OP_KTH,   '0, '1);
    send_item(OP_KTH,   '0, '0);
    send_item(OP_KTH,   '0, wide_random());
  endtask

  // The receiver drops ready at random according to the current stall rate.
  always @(posedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Each result item is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, answer %h ok %b basis_size %0d",
                 $time, got.answer, got.ok, got.basis_size);
      end else begin
        want = results_due.pop_front();
        if (got.answer !== want.answer) begin
          mismatches++;
          $display("%0t: answer mismatch, expected %h, actual %h",
                   $time, want.answer, got.answer);
        end
        if (got.ok !== want.ok) begin
          mismatches++;
          $display("%0t: ok mismatch, expected %b, actual %b", $time, want.ok, got.ok);
        end
        if (got.basis_size !== want.basis_size) begin
          mismatches++;
          $display("%0t: basis_size mismatch, expected %0d, actual %0d",
                   $time, want.basis_size, got.basis_size);
        end
      end
    end
  end

  // A run that stops moving items on both sides for too long has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, results_due.size());
      $display("xor_linear_basis_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    mismatches   = 0;
    ok_seen      = 0;
    quiet_cycles = 0;
    op_seen      = '{default: 0};
    pivot_mask   = '0;
    rank_now     = '0;
    insert_total = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_basis();
    test_insert_and_query();
    test_random_traffic(465, 8,  0,  0,  1'b0);
    test_random_traffic(465, 24, 53, 0,  1'b1);
    test_random_traffic(465, 44, 0,  53, 1'b0);
    test_random_traffic(465, 64, 31, 31, 1'b0);
    test_full_basis_limits();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d inserts, %0d kth, %0d count and %0d rank items, %0d with ok set;",
             op_seen[OP_INSERT], op_seen[OP_KTH], op_seen[OP_COUNT], op_seen[OP_RANK],
             ok_seen);
    $display("the basis ended with %0d words after %0d inserted words.",
             rank_now, insert_total);
    if (mismatches == 0) begin
      $display("xor_linear_basis_engine test passed");
    end else begin
      $display("xor_linear_basis_engine test failed");
    end
    $finish;
  end

endmodule
